[rtl/core/aapc_pkg.sv]
// ----------------------------------------------------------------------------
// aapc_pkg
// Shared types, register indexes, tables and helper steps for the arc
// pixel coverage engine.
// ----------------------------------------------------------------------------
`default_nettype none

package aapc_pkg;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  localparam logic [CfgIdxW-1:0] CfgOuterRadius   = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgInnerRadius   = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgOpacity       = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgStartSine     = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgStartNegCos   = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgEndSine       = 3'd5;
  localparam logic [CfgIdxW-1:0] CfgEndNegCos     = 3'd6;
  localparam logic [CfgIdxW-1:0] CfgMode          = 3'd7;

  localparam logic [1:0] KindSmall = 2'd1;
  localparam logic [1:0] KindBig   = 2'd2;

  localparam logic [15:0] CapNumer   = 16'hff00;
  localparam logic [7:0]  GradLimit  = 8'd250;
  localparam logic [7:0]  AngCentre  = 8'd191;
  localparam logic [7:0]  AngLeft    = 8'd63;
  localparam logic [7:0]  AngDown    = 8'd0;
  localparam logic [7:0]  AngUp      = 8'd127;
  localparam logic [7:0]  OctScale   = 8'd45;
  localparam logic [17:0] CutLimit   = 18'd255;
  localparam logic [24:0] CutFar     = 25'd32768;
  localparam int unsigned DivSteps   = 16;

  typedef struct packed {
    logic signed [7:0] offset_x;
    logic signed [7:0] offset_y;
  } in_t;

  typedef struct packed {
    logic       draw;
    logic [7:0] coverage;
    logic [7:0] gradient_pos;
  } out_t;

  localparam logic [5:0] OCT_TAB [46] = '{
    6'd0,  6'd1,  6'd1,  6'd2,  6'd2,  6'd3,  6'd4,  6'd4,  6'd5,  6'd6,  6'd7,
    6'd7,  6'd8,  6'd9,  6'd9,  6'd10, 6'd11, 6'd12, 6'd12, 6'd13, 6'd14,
    6'd14, 6'd15, 6'd16, 6'd16, 6'd17, 6'd18, 6'd18, 6'd19, 6'd20, 6'd20,
    6'd21, 6'd22, 6'd22, 6'd23, 6'd24, 6'd24, 6'd25, 6'd26, 6'd26, 6'd27,
    6'd28, 6'd28, 6'd29, 6'd30, 6'd32};

  localparam logic [2:0] ZONE_TAB [8] = '{
    3'd2, 3'd3, 3'd1, 3'd0, 3'd5, 3'd4, 3'd6, 3'd7};

  // one bit of a 16 by 8 restoring division: returns {rem, num/quotient}
  function automatic logic [23:0] div_step(logic [7:0] rem, logic [15:0] num,
                                           logic [7:0] den);
    logic [8:0] sh;
    logic [7:0] nr;
    logic       qb;
    sh = {rem, num[15]};
    qb = (sh >= {1'b0, den});
    nr = qb ? 8'(sh - {1'b0, den}) : sh[7:0];
    return {nr, num[14:0], qb};
  endfunction

  // one quotient bit of the octant ratio division: returns {qbit, rem}
  function automatic logic [13:0] ang_step(logic [12:0] rem, logic [7:0] den,
                                           int unsigned sh);
    logic [13:0] d;
    logic        qb;
    d  = 14'(den) << sh;
    qb = ({1'b0, rem} >= d);
    return {qb, qb ? 13'({1'b0, rem} - d) : rem};
  endfunction

endpackage

`default_nettype wire

[rtl/core/antialiased_arc_pixel_coverage.sv]
// ----------------------------------------------------------------------------
// antialiased_arc_pixel_coverage
// Five stage pipeline: ring edges, arc cut or round caps, octant angle.
// One pixel per cycle while the output is not stalled and no rebuild runs.
// The octant ratio is divided over stages 2 to 4, two quotient bits each.
// After reset and after every register write, three reciprocals are rebuilt
// by bit-serial dividers: input is held off until they finish.
// Reset clears config to defaults and empties the pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module antialiased_arc_pixel_coverage (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          cfg_we_i,
  input  wire [aapc_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire [aapc_pkg::CfgDataW-1:0] cfg_data_i,
  input  wire                          in_valid_i,
  output logic                         in_ready_o,
  input  aapc_pkg::in_t                in_data_i,
  output logic                         out_valid_o,
  input  wire                          out_ready_i,
  output aapc_pkg::out_t               out_data_o
);
  import aapc_pkg::*;

  // configuration
  logic [6:0] orad_q, irad_q;
  logic [7:0] opac_q;
  logic signed [15:0] ss_q, snc_q, es_q, enc_q;
  logic [3:0] mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      orad_q <= '0; irad_q <= '0; opac_q <= 8'hff;
      ss_q <= '0; snc_q <= '0; es_q <= '0; enc_q <= '0; mode_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgOuterRadius: orad_q <= cfg_data_i[6:0];
        CfgInnerRadius: irad_q <= cfg_data_i[6:0];
        CfgOpacity:     opac_q <= cfg_data_i[7:0];
        CfgStartSine:   ss_q   <= $signed(cfg_data_i);
        CfgStartNegCos: snc_q  <= $signed(cfg_data_i);
        CfgEndSine:     es_q   <= $signed(cfg_data_i);
        CfgEndNegCos:   enc_q  <= $signed(cfg_data_i);
        CfgMode:        mode_q <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  // derived constants, registered
  logic signed [7:0] dcap;
  logic [6:0] len, rr;
  assign dcap = $signed({1'b0, orad_q}) - $signed({1'b0, irad_q});
  assign len  = 7'(({1'b0, orad_q} + {1'b0, irad_q}) >> 1);
  assign rr   = dcap[7] ? 7'd0 : 7'(dcap[6:1]);

  logic [14:0] rmax_q, r2_q, r1_q, rmin_q;
  logic [12:0] r2c_q, rmaxc_q;
  logic [6:0]  lim_q;
  logic        capok_q;
  logic signed [8:0] pcx_q [2];
  logic signed [8:0] pcy_q [2];
  logic signed [23:0] pp [4];

  assign pp[0] = 24'(ss_q)  * $signed({17'd0, len}) + 24'sd16384;
  assign pp[1] = 24'(snc_q) * $signed({17'd0, len}) + 24'sd16384;
  assign pp[2] = 24'(es_q)  * $signed({17'd0, len}) + 24'sd16384;
  assign pp[3] = 24'(enc_q) * $signed({17'd0, len}) + 24'sd16384;

  always_ff @(posedge clk_i) begin
    rmax_q  <= 15'(({8'd0, orad_q} + 15'd1) * ({8'd0, orad_q} + 15'd1));
    r2_q    <= 15'({8'd0, orad_q} * {8'd0, orad_q});
    r1_q    <= 15'({8'd0, irad_q} * {8'd0, irad_q});
    rmin_q  <= (irad_q != 0) ?
               15'(({8'd0, irad_q} - 15'd1) * ({8'd0, irad_q} - 15'd1)) : 15'd0;
    r2c_q   <= 13'({6'd0, rr} * {6'd0, rr});
    rmaxc_q <= 13'(({6'd0, rr} + 13'd1) * ({6'd0, rr} + 13'd1));
    lim_q   <= rr + 7'd1;
    capok_q <= !dcap[7];
    pcx_q[0] <= -9'(pp[0] >>> 15);
    pcy_q[0] <= -9'(pp[1] >>> 15);
    pcx_q[1] <= -9'(pp[2] >>> 15);
    pcy_q[1] <= -9'(pp[3] >>> 15);
  end

  // bit-serial reciprocal dividers
  logic        start_q;
  logic [4:0]  cnt_q;
  logic [15:0] nuo_q, nui_q, nuc_q;
  logic [7:0]  reo_q, rei_q, rec_q;
  logic [7:0]  deo_q, dei_q, dec_q;
  logic        busy;
  logic [23:0] so, si, sc;

  assign busy = start_q || (cnt_q != 0);
  assign so = div_step(reo_q, nuo_q, deo_q);
  assign si = div_step(rei_q, nui_q, dei_q);
  assign sc = div_step(rec_q, nuc_q, dec_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= 1'b1;
      cnt_q   <= '0;
    end else begin
      start_q <= cfg_we_i;
      if (start_q) cnt_q <= 5'(DivSteps);
      else if (cnt_q != 0) cnt_q <= cnt_q - 5'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_q) begin
      nuo_q <= {opac_q, 8'd0}; nui_q <= {opac_q, 8'd0}; nuc_q <= CapNumer;
      reo_q <= '0; rei_q <= '0; rec_q <= '0;
      deo_q <= {orad_q, 1'b1};
      dei_q <= (irad_q != 0) ? 8'({irad_q, 1'b0} - 8'd1) : 8'd1;
      dec_q <= {rr, 1'b1};
    end else if (cnt_q != 0) begin
      {reo_q, nuo_q} <= so;
      {rei_q, nui_q} <= si;
      {rec_q, nuc_q} <= sc;
    end
  end

  // pipeline control
  logic adv;
  logic v1_q, v2_q, v3_q, v4_q, v5_q;
  assign adv        = !v5_q || out_ready_i;
  assign in_ready_o = adv && !busy;
  assign out_valid_o = v5_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      {v1_q, v2_q, v3_q, v4_q, v5_q} <= '0;
    end else if (adv) begin
      v1_q <= in_valid_i && !busy;
      v2_q <= v1_q; v3_q <= v2_q; v4_q <= v3_q; v5_q <= v4_q;
    end
  end

  // stage 1
  logic signed [7:0] dx, dy;
  logic signed [16:0] sqx, sqy;
  logic [7:0] ax, ay, amin, amax;
  logic signed [9:0] cxd [2];
  logic signed [9:0] cyd [2];
  assign dx  = in_data_i.offset_x;
  assign dy  = in_data_i.offset_y;
  assign sqx = 17'(dx) * 17'(dx);
  assign sqy = 17'(dy) * 17'(dy);
  assign ax  = dx[7] ? 8'(-dx) : 8'(dx);
  assign ay  = dy[7] ? 8'(-dy) : 8'(dy);
  assign amin = (ax > ay) ? ay : ax;
  assign amax = (ax > ay) ? ax : ay;
  for (genvar k = 0; k < 2; k++) begin : g_cd
    assign cxd[k] = 10'(dx) - 10'(pcx_q[k]);
    assign cyd[k] = 10'(dy) - 10'(pcy_q[k]);
  end

  logic [15:0] s1_rsq_q;
  logic signed [23:0] s1_pa_q, s1_pb_q, s1_pc_q, s1_pd_q;
  logic [9:0] s1_cx_q [2];
  logic [9:0] s1_cy_q [2];
  logic [12:0] s1_num_q;
  logic [7:0]  s1_den_q;
  logic s1_near_q, s1_xz_q, s1_yz_q, s1_xn_q, s1_yn_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_rsq_q <= 16'(sqx + sqy);
      s1_pa_q  <= 24'(dx) * 24'(snc_q);
      s1_pb_q  <= 24'(dy) * 24'(ss_q);
      s1_pc_q  <= 24'(dy) * 24'(es_q);
      s1_pd_q  <= 24'(dx) * 24'(enc_q);
      for (int k = 0; k < 2; k++) begin
        s1_cx_q[k] <= cxd[k][9] ? 10'(-cxd[k]) : 10'(cxd[k]);
        s1_cy_q[k] <= cyd[k][9] ? 10'(-cyd[k]) : 10'(cyd[k]);
      end
      s1_num_q  <= 13'({5'd0, amin} * {5'd0, OctScale});
      s1_den_q  <= amax;
      s1_near_q <= !(ax > ay);
      s1_xz_q   <= (dx == 0);
      s1_yz_q   <= (dy == 0);
      s1_xn_q   <= dx[7];
      s1_yn_q   <= dy[7];
    end
  end

  // stage 2
  logic [13:0] a5, a4;
  assign a5 = ang_step(s1_num_q, s1_den_q, 5);
  assign a4 = ang_step(a5[12:0], s1_den_q, 4);

  logic signed [24:0] s2_ds_q, s2_de_q;
  logic s2_out_q, s2_oedge_q, s2_iedge_q;
  logic [7:0] s2_diff_q;
  logic [12:0] s2_t_q [2];
  logic [1:0]  s2_in_q;
  logic [1:0]  s2_rl_q;
  logic [12:0] s2_rem_q;
  logic [7:0]  s2_den_q;
  logic [5:0]  s2_q_q;
  logic s2_near_q, s2_xz_q, s2_yz_q, s2_xn_q, s2_yn_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s2_ds_q <= 25'(s1_pa_q) - 25'(s1_pb_q);
      s2_de_q <= 25'(s1_pc_q) - 25'(s1_pd_q);
      s2_out_q   <= (s1_rsq_q >= {1'b0, rmax_q}) || (s1_rsq_q < {1'b0, rmin_q});
      s2_oedge_q <= (s1_rsq_q > {1'b0, r2_q});
      s2_iedge_q <= (s1_rsq_q < {1'b0, r1_q});
      s2_diff_q  <= (s1_rsq_q > {1'b0, r2_q}) ? 8'({1'b0, rmax_q} - s1_rsq_q)
                                               : 8'(s1_rsq_q - {1'b0, rmin_q});
      for (int k = 0; k < 2; k++) begin
        s2_in_q[k] <= capok_q && (s1_cx_q[k] < {3'd0, lim_q})
                      && (s1_cy_q[k] < {3'd0, lim_q});
        s2_t_q[k]  <= 13'({7'd0, s1_cx_q[k][5:0]} * {7'd0, s1_cx_q[k][5:0]})
                    + 13'({7'd0, s1_cy_q[k][5:0]} * {7'd0, s1_cy_q[k][5:0]});
      end
      s2_rl_q   <= s1_rsq_q[1:0];
      s2_rem_q  <= a4[12:0];
      s2_den_q  <= s1_den_q;
      s2_q_q    <= {a5[13], a4[13], 4'd0};
      s2_near_q <= s1_near_q;
      s2_xz_q <= s1_xz_q; s2_yz_q <= s1_yz_q;
      s2_xn_q <= s1_xn_q; s2_yn_q <= s1_yn_q;
    end
  end

  // stage 3
  logic [13:0] a3, a2;
  logic [24:0] sd, ed, mind;
  logic sdiff_s, sdiff_e;
  assign a3 = ang_step(s2_rem_q, s2_den_q, 3);
  assign a2 = ang_step(a3[12:0], s2_den_q, 2);
  assign sdiff_s = (!s2_xz_q && (s2_xn_q != ss_q[15]))
                || (!s2_yz_q && (s2_yn_q != snc_q[15]));
  assign sdiff_e = (!s2_xz_q && (s2_xn_q != es_q[15]))
                || (!s2_yz_q && (s2_yn_q != enc_q[15]));
  assign sd   = !sdiff_s ? CutFar : (s2_ds_q[24] ? 25'(-s2_ds_q) : 25'(s2_ds_q));
  assign ed   = !sdiff_e ? CutFar : (s2_de_q[24] ? 25'(-s2_de_q) : 25'(s2_de_q));
  assign mind = (sd < ed) ? sd : ed;

  logic s3_out_q, s3_edge_q, s3_inside_q;
  logic [23:0] s3_cov_q;
  logic [1:0]  s3_full_q, s3_part_q;
  logic [22:0] s3_ap_q [2];
  logic [17:0] s3_ms_q;
  logic [1:0]  s3_rl_q;
  logic [12:0] s3_rem_q;
  logic [7:0]  s3_den_q;
  logic [5:0]  s3_q_q;
  logic s3_near_q, s3_xz_q, s3_yz_q, s3_xn_q, s3_yn_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s3_out_q  <= s2_out_q;
      s3_edge_q <= s2_oedge_q || s2_iedge_q;
      s3_cov_q  <= {16'd0, s2_diff_q} * {8'd0, (s2_oedge_q ? nuo_q : nui_q)};
      s3_inside_q <= (mode_q[1:0] == KindBig)
                     ? (s2_ds_q > 0 || s2_de_q > 0)
                     : (!s2_ds_q[24] && !s2_de_q[24]);
      for (int k = 0; k < 2; k++) begin
        s3_full_q[k] <= s2_in_q[k] && (s2_t_q[k] <= r2c_q);
        s3_part_q[k] <= s2_in_q[k] && (s2_t_q[k] > r2c_q) && (s2_t_q[k] < rmaxc_q);
        s3_ap_q[k]   <= 23'({10'd0, 7'(rmaxc_q - s2_t_q[k])} * {7'd0, nuc_q});
      end
      s3_ms_q   <= 18'(mind >> 7);
      s3_rl_q   <= s2_rl_q;
      s3_rem_q  <= a2[12:0];
      s3_den_q  <= s2_den_q;
      s3_q_q    <= {s2_q_q[5:4], a3[13], a2[13], 2'd0};
      s3_near_q <= s2_near_q;
      s3_xz_q <= s2_xz_q; s3_yz_q <= s2_yz_q;
      s3_xn_q <= s2_xn_q; s3_yn_q <= s2_yn_q;
    end
  end

  // stage 4
  logic [13:0] a1, a0;
  logic [7:0] ca [2];
  logic [7:0] best;
  logic [7:0] msoft;
  assign a1 = ang_step(s3_rem_q, s3_den_q, 1);
  assign a0 = ang_step(a1[12:0], s3_den_q, 0);
  for (genvar k = 0; k < 2; k++) begin : g_ca
    assign ca[k] = s3_full_q[k] ? 8'hff : (s3_part_q[k] ? s3_ap_q[k][15:8] : 8'd0);
  end
  assign best  = (ca[1] > ca[0]) ? ca[1] : ca[0];
  assign msoft = 8'(CutLimit - s3_ms_q);

  logic s4_out_q, s4_inside_q, s4_skip_q;
  logic [7:0]  s4_cov_q, s4_m_q;
  logic [1:0]  s4_rl_q;
  logic [5:0]  s4_th_q;
  logic s4_near_q, s4_xz_q, s4_yz_q, s4_xn_q, s4_yn_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s4_out_q    <= s3_out_q;
      s4_inside_q <= s3_inside_q;
      s4_cov_q    <= s3_edge_q ? s3_cov_q[15:8] : opac_q;
      if (mode_q[2]) begin
        s4_skip_q <= (best == 0);
        s4_m_q    <= 8'(({8'd0, best} * {8'd0, opac_q}) >> 8);
      end else begin
        s4_skip_q <= (s3_ms_q >= CutLimit);
        s4_m_q    <= 8'(({8'd0, msoft} * {8'd0, opac_q}) >> 8);
      end
      s4_rl_q   <= s3_rl_q;
      s4_th_q   <= {s3_q_q[5:2], a1[13], a0[13]};
      s4_near_q <= s3_near_q;
      s4_xz_q <= s3_xz_q; s4_yz_q <= s3_yz_q;
      s4_xn_q <= s3_xn_q; s4_yn_q <= s3_yn_q;
    end
  end

  // stage 5: output register
  logic       cut, drop;
  logic [7:0] cov, base, ang, grad;
  logic [2:0] zone;
  assign cut  = ((mode_q[1:0] == KindSmall) || (mode_q[1:0] == KindBig)) && !s4_inside_q;
  assign drop = s4_out_q || (cut && s4_skip_q);
  assign cov  = (cut && (s4_m_q < s4_cov_q)) ? s4_m_q : s4_cov_q;
  assign base = {2'd0, OCT_TAB[(s4_th_q > 6'd45) ? 6'd45 : s4_th_q]};
  assign zone = ZONE_TAB[{!s4_xn_q, !s4_yn_q, s4_near_q}];

  always_comb begin
    if (s4_yz_q) begin
      ang = s4_xn_q ? AngLeft : AngCentre;
    end else if (s4_xz_q) begin
      ang = s4_yn_q ? AngUp : AngDown;
    end else begin
      case (zone)
        3'd0:    ang = base;
        3'd1:    ang = 8'd63 - base;
        3'd2:    ang = 8'd64 + base;
        3'd3:    ang = 8'd127 - base;
        3'd4:    ang = 8'd128 + base;
        3'd5:    ang = 8'd191 - base;
        3'd6:    ang = 8'd192 + base;
        default: ang = 8'd255 - base;
      endcase
    end
    grad = (ang < GradLimit) ? ang + {6'd0, s4_rl_q} : ang;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_data_o.draw         <= !drop;
      out_data_o.coverage     <= drop ? 8'd0 : cov;
      out_data_o.gradient_pos <= (drop || !mode_q[3]) ? 8'd0 : grad;
    end
  end

  // checks
  a_skip_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.draw |->
      out_data_o.coverage == 0 && out_data_o.gradient_pos == 0)
    else $error("skipped pixel carries payload");

  a_grad_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !mode_q[3] |-> out_data_o.gradient_pos == 0)
    else $error("gradient set while disabled");

  a_cov_opac: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !busy |-> out_data_o.coverage <= opac_q)
    else $error("coverage above opacity");

  a_busy_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> !in_ready_o ##1 !in_ready_o)
    else $error("input taken during reciprocal rebuild");

endmodule

`default_nettype wire
